// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL of the alarm blink sequencer.
// Depends on nothing; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("assertion failed");

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk_sig, rstn_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk_sig, rstn_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rstn_sig, cond)

`endif

`endif

// ===== design/cabs_pkg.sv =====
// Types and constants of the alarm blink sequencer.
// Used by cabs_match, cabs_seq and the top level; depends on nothing.
package cabs_pkg;

    // Two alarm slots are always present in the register map.
    localparam int ALARM_SLOTS = 2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_A0_WEEKDAY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_A0_HOUR    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_A0_MINUTE  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_A0_SECOND  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_A1_WEEKDAY = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_A1_HOUR    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_A1_MINUTE  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_A1_SECOND  = 4'd7;

    // Sequencer phase codes.
    localparam logic [2:0] PH_WAITING   = 3'd0;
    localparam logic [2:0] PH_START     = 3'd1;
    localparam logic [2:0] PH_DELAY_ON  = 3'd2;
    localparam logic [2:0] PH_ON        = 3'd3;
    localparam logic [2:0] PH_DELAY_OFF = 3'd4;
    localparam logic [2:0] PH_OFF       = 3'd5;
    localparam logic [2:0] PH_FINISH    = 3'd6;
    localparam logic [2:0] PH_UNUSED    = 3'd7;

    localparam logic [2:0] DELAY_RELOAD = 3'd5;

    // Item kinds carried on s_tuser.
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // One alarm entry, every field two's complement; all ones is the wildcard.
    typedef struct packed {
        logic [3:0] weekday;
        logic [5:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } alarm_cfg_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } clock_now_t;

    typedef struct packed {
        logic                   func;
        clock_now_t             now;
    } in_item_t;

    typedef struct packed {
        logic [ALARM_SLOTS-1:0] armed_mask;
        logic [ALARM_SLOTS-1:0] fired_mask;
        logic [2:0]             phase;
        logic                   led_level;
    } result_t;

endpackage

// ===== design/cron_alarm_blink_sequencer.sv =====
// Alarm-match blink sequencer. Each request on the slave stream is either an
// alarm check (tuser 0) carrying the current weekday, hour, minute and second,
// or a blink tick (tuser 1). Every request gives exactly one result on the
// master stream. The block takes one request per clock cycle while the output
// is not stalled; a request lands in an input register, then the match and
// sequencer logic runs on it and updates the sequencer state as it writes the
// result register. Backpressure on m_tready holds the result register, and
// the input register too once it is full. Alarm registers are written over
// the cfg channel, which is always ready; write them only while no request
// is in flight. A register value of all ones is a wildcard; indexes beyond
// the register list are ignored.
`include "assert_macros.svh"

module cron_alarm_blink_sequencer
    import cabs_pkg::*;
#(
    parameter int NUM_ALARMS = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0: now_weekday[2:0], now_hour[7:3], now_minute[13:8],
    // now_second[19:14], zero padding[23:20]
    input  logic [23:0]            s_tdata,
    // s_tuser: func (0 alarm check, 1 blink tick)
    input  logic                   s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata from bit 0: led_level[0], phase[3:1], fired_mask[5:4],
    // armed_mask[7:6]
    output logic [7:0]             m_tdata
);

    alarm_cfg_t            alarm_cfg_reg [ALARM_SLOTS];
    in_item_t              in_reg;
    logic                  in_valid_reg;
    result_t               out_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  step_en;
    logic [NUM_ALARMS-1:0] hit;
    result_t               result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_cfg_reg[0] <= '{weekday: 4'hF, hour: 6'h3F, minute: 7'h7F, second: 7'd0};
            alarm_cfg_reg[1] <= '{weekday: 4'hF, hour: 6'h3F, minute: 7'h7F, second: 7'd30};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_A0_WEEKDAY: alarm_cfg_reg[0].weekday <= cfg_data[3:0];
                REG_A0_HOUR:    alarm_cfg_reg[0].hour    <= cfg_data[5:0];
                REG_A0_MINUTE:  alarm_cfg_reg[0].minute  <= cfg_data;
                REG_A0_SECOND:  alarm_cfg_reg[0].second  <= cfg_data;
                REG_A1_WEEKDAY: alarm_cfg_reg[1].weekday <= cfg_data[3:0];
                REG_A1_HOUR:    alarm_cfg_reg[1].hour    <= cfg_data[5:0];
                REG_A1_MINUTE:  alarm_cfg_reg[1].minute  <= cfg_data;
                REG_A1_SECOND:  alarm_cfg_reg[1].second  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The result register drains or is empty; everything behind it moves.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.func       <= s_tuser;
            in_reg.now.weekday <= s_tdata[2:0];
            in_reg.now.hour    <= s_tdata[7:3];
            in_reg.now.minute  <= s_tdata[13:8];
            in_reg.now.second  <= s_tdata[19:14];
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    cabs_match #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_match (
        .alarm_cfg  (alarm_cfg_reg),
        .now        (in_reg.now),
        .hit        (hit)
    );

    cabs_seq #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .func       (in_reg.func),
        .hit        (hit),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.armed_mask, out_reg.fired_mask, out_reg.phase, out_reg.led_level};

    // An alarm that fires always leaves the sequencer at START.
    `ASSERT_AT(a_fire_sets_start, clk, rst_n, (m_tvalid && (out_reg.fired_mask != 2'b00)) |-> (out_reg.phase == PH_START))
    // A fired entry has just been disarmed.
    `ASSERT_NEVER(a_fired_not_armed, clk, rst_n, m_tvalid && ((out_reg.fired_mask & out_reg.armed_mask) != 2'b00))
    // An empty result register never blocks a new request.
    `ASSERT_AT(a_ready_when_empty, clk, rst_n, !out_valid_reg |-> s_tready)
    // The unused phase code is never reached.
    `ASSERT_NEVER(a_no_unused_phase, clk, rst_n, m_tvalid && (out_reg.phase == PH_UNUSED))

endmodule

// ===== design/cabs_match.sv =====
// Wildcard compare of the current time against every alarm entry.
// Depends on cabs_pkg.
module cabs_match
    import cabs_pkg::*;
#(
    parameter int NUM_ALARMS = 2
)
(
    input  alarm_cfg_t            alarm_cfg [ALARM_SLOTS],
    input  clock_now_t            now,
    output logic [NUM_ALARMS-1:0] hit
);

    // A register field matches when it is all ones (wildcard) or when it is
    // non-negative and equal to the time field; zero-extending the time by
    // one bit covers the sign test in the same compare.
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            hit[i] = ((&alarm_cfg[i].weekday) || (alarm_cfg[i].weekday == {1'b0, now.weekday}))
                  && ((&alarm_cfg[i].hour)    || (alarm_cfg[i].hour    == {1'b0, now.hour}))
                  && ((&alarm_cfg[i].minute)  || (alarm_cfg[i].minute  == {1'b0, now.minute}))
                  && ((&alarm_cfg[i].second)  || (alarm_cfg[i].second  == {1'b0, now.second}));
        end
    end

endmodule

// ===== design/cabs_seq.sv =====
// Blink sequencer state: phase, delay counters, LED level and alarm arm bits.
// Depends on cabs_pkg; takes the match vector from cabs_match.
module cabs_seq
    import cabs_pkg::*;
#(
    parameter int NUM_ALARMS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  func,
    input  logic [NUM_ALARMS-1:0] hit,
    output result_t               result
);

    logic [2:0]            phase_reg, phase_next;
    logic [2:0]            on_cnt_reg, on_cnt_next;
    logic [2:0]            off_cnt_reg, off_cnt_next;
    logic                  pin_reg, pin_next;
    logic [NUM_ALARMS-1:0] armed_reg, armed_next;
    logic [NUM_ALARMS-1:0] fired;
    logic [ALARM_SLOTS-1:0] fired_ext;
    logic [ALARM_SLOTS-1:0] armed_ext;

    always_comb
    begin
        phase_next   = phase_reg;
        on_cnt_next  = on_cnt_reg;
        off_cnt_next = off_cnt_reg;
        pin_next     = pin_reg;
        armed_next   = armed_reg;
        fired        = '0;
        if (func == FUNC_CHECK)
        begin
            // A firing alarm restarts the blink but leaves the counters alone.
            fired      = armed_reg & hit;
            armed_next = armed_reg & ~hit;
            if (|fired)
            begin
                phase_next = PH_START;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    phase_next = PH_DELAY_ON;
                end
                PH_DELAY_ON:
                begin
                    if (on_cnt_reg != 3'd0)
                    begin
                        on_cnt_next = on_cnt_reg - 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_ON;
                    end
                end
                PH_ON:
                begin
                    pin_next   = 1'b0;
                    phase_next = PH_DELAY_OFF;
                end
                PH_DELAY_OFF:
                begin
                    if (off_cnt_reg != 3'd0)
                    begin
                        off_cnt_next = off_cnt_reg - 3'd1;
                    end
                    else
                    begin
                        phase_next = PH_OFF;
                    end
                end
                PH_OFF:
                begin
                    pin_next   = 1'b1;
                    phase_next = PH_FINISH;
                end
                PH_FINISH:
                begin
                    on_cnt_next  = DELAY_RELOAD;
                    off_cnt_next = DELAY_RELOAD;
                    phase_next   = PH_WAITING;
                    armed_next   = '1;
                end
                default:
                begin
                    // Waiting and the unused code hold on a tick.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAITING;
            on_cnt_reg  <= DELAY_RELOAD;
            off_cnt_reg <= DELAY_RELOAD;
            pin_reg     <= 1'b1;
            armed_reg   <= '1;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            on_cnt_reg  <= on_cnt_next;
            off_cnt_reg <= off_cnt_next;
            pin_reg     <= pin_next;
            armed_reg   <= armed_next;
        end
    end

    // Slots beyond NUM_ALARMS always report zero.
    for (genvar i = 0; i < ALARM_SLOTS; i++)
    begin : g_slot
        if (i < NUM_ALARMS)
        begin : g_used
            assign fired_ext[i] = fired[i];
            assign armed_ext[i] = armed_next[i];
        end
        else
        begin : g_unused
            assign fired_ext[i] = 1'b0;
            assign armed_ext[i] = 1'b0;
        end
    end

    assign result.led_level  = pin_next;
    assign result.phase      = phase_next;
    assign result.fired_mask = fired_ext;
    assign result.armed_mask = armed_ext;

endmodule

// ===== sim/tb_cron_alarm_blink_sequencer.sv =====
// Self-checking testbench for cron_alarm_blink_sequencer: a scoreboard class predicts every result.
// Random request, stall and register traffic runs under several alarm settings.
// Depends on cabs_pkg and the block's RTL; reads no files.
module tb_cron_alarm_blink_sequencer;
    import cabs_pkg::*;

    localparam int CYCLE_LIMIT        = 150000;
    localparam int RANDOM_PER_SETTING = 66;
    localparam int WILDCARD           = -1;
    localparam int ENTRY_STRIDE       = REG_A1_WEEKDAY - REG_A0_WEEKDAY;
    localparam int REG_COUNT          = REG_A1_SECOND + 1;
    localparam int INDEX_TOP          = (1 << CFG_INDEX_W) - 1;
    localparam int NOW_W              = $bits(clock_now_t);

    // Styles of alarm register settings.
    localparam int SET_WILDCARD = 0;
    localparam int SET_TOP      = 1;
    localparam int SET_BOTTOM   = 2;
    localparam int SET_IN_RANGE = 3;
    localparam int SET_RAW      = 4;

    class alarm_blink_scoreboard;
        logic [CFG_DATA_W-1:0]  alarm_regs [REG_COUNT];
        logic [2:0]             phase;
        logic [2:0]             on_left;
        logic [2:0]             off_left;
        logic [ALARM_SLOTS-1:0] armed;
        logic                   pin;
        result_t                pending_results [$];
        int                     requests;
        int                     results;
        int                     firings;
        int                     errors;

        function new();
            alarm_regs[REG_A0_WEEKDAY] = '1;
            alarm_regs[REG_A0_HOUR]    = '1;
            alarm_regs[REG_A0_MINUTE]  = '1;
            alarm_regs[REG_A0_SECOND]  = 7'd0;
            alarm_regs[REG_A1_WEEKDAY] = '1;
            alarm_regs[REG_A1_HOUR]    = '1;
            alarm_regs[REG_A1_MINUTE]  = '1;
            alarm_regs[REG_A1_SECOND]  = 7'd30;
            phase    = PH_WAITING;
            on_left  = DELAY_RELOAD;
            off_left = DELAY_RELOAD;
            armed    = '1;
            pin      = 1'b1;
            requests = 0;
            results  = 0;
            firings  = 0;
            errors   = 0;
        endfunction

        function int reg_width(int idx);
            case (idx % ENTRY_STRIDE)
                REG_A0_WEEKDAY: return 4;
                REG_A0_HOUR:    return 6;
                default:        return 7;
            endcase
        endfunction

        // Registers keep only their own width and are read as two's complement.
        function int reg_signed(int idx);
            int w;
            int v;
            w = reg_width(idx);
            v = int'(alarm_regs[idx]) & ((1 << w) - 1);
            if (v >= (1 << (w - 1)))
            begin
                v = v - (1 << w);
            end
            return v;
        endfunction

        function void set_register(int idx, logic [CFG_DATA_W-1:0] data);
            if (idx < REG_COUNT)
            begin
                alarm_regs[idx] = data;
            end
        endfunction

        function bit field_hit(int idx, int now_val);
            int r;
            r = reg_signed(idx);
            return (r == WILDCARD) || (r >= 0 && r == now_val);
        endfunction

        function void step_sequencer();
            case (phase)
                PH_START:
                    phase = PH_DELAY_ON;
                PH_DELAY_ON:
                    if (on_left != 3'd0)
                        on_left = on_left - 3'd1;
                    else
                        phase = PH_ON;
                PH_ON:
                begin
                    pin   = 1'b0;
                    phase = PH_DELAY_OFF;
                end
                PH_DELAY_OFF:
                    if (off_left != 3'd0)
                        off_left = off_left - 3'd1;
                    else
                        phase = PH_OFF;
                PH_OFF:
                begin
                    pin   = 1'b1;
                    phase = PH_FINISH;
                end
                PH_FINISH:
                begin
                    on_left  = DELAY_RELOAD;
                    off_left = DELAY_RELOAD;
                    phase    = PH_WAITING;
                    armed    = '1;
                end
                default:
                    ;
            endcase
        endfunction

        function void note_request(logic func, clock_now_t now);
            result_t                prediction;
            logic [ALARM_SLOTS-1:0] fired;
            int                     b;
            fired = '0;
            if (func == FUNC_CHECK)
            begin
                for (int i = 0; i < ALARM_SLOTS; i++)
                begin
                    b = i * ENTRY_STRIDE;
                    if (armed[i] && field_hit(b + REG_A0_WEEKDAY, int'(now.weekday)) &&
                        field_hit(b + REG_A0_HOUR, int'(now.hour)) &&
                        field_hit(b + REG_A0_MINUTE, int'(now.minute)) &&
                        field_hit(b + REG_A0_SECOND, int'(now.second)))
                    begin
                        // A hit restarts the blink but leaves the delay counters alone.
                        armed[i] = 1'b0;
                        fired[i] = 1'b1;
                        phase    = PH_START;
                        firings++;
                    end
                end
            end
            else
            begin
                step_sequencer();
            end
            prediction.led_level  = pin;
            prediction.phase      = phase;
            prediction.fired_mask = fired;
            prediction.armed_mask = armed;
            pending_results.push_back(prediction);
            requests++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            results++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %h arrived with no request outstanding", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.led_level !== want.led_level || got.phase !== want.phase ||
                got.fired_mask !== want.fired_mask || got.armed_mask !== want.armed_mask)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: #%0d exp/act led %b/%b phase %0d/%0d fired %b/%b armed %b/%b",
                             results, want.led_level, got.led_level, want.phase, got.phase,
                             want.fired_mask, got.fired_mask, want.armed_mask, got.armed_mask);
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;

    alarm_blink_scoreboard board;
    bit                    no_idle = 1'b0;
    int                    cycle_count = 0;
    int                    settings_loaded = 0;

    cron_alarm_blink_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_cron_alarm_blink_sequencer: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(result_t'(m_tdata));
    end

    // Result side: stall a random number of cycles, then hold ready until one result is taken.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic send_request(logic func, clock_now_t now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, now.second, now.minute, now.hour, now.weekday};
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_request(func, now);
    endtask

    task automatic send_ticks(int count);
        clock_now_t noise;
        for (int n = 0; n < count; n++)
        begin
            noise = NOW_W'($urandom);
            send_request(FUNC_TICK, noise);
        end
    endtask

    task automatic write_alarm_reg(int idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_INDEX_W-1:0];
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        board.set_register(idx, data);
    endtask

    // Lets every outstanding result come back so the registers can be rewritten.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_alarms(int style);
        int w;
        int v;
        int mask;
        // Writes past the register list must leave every entry untouched.
        write_alarm_reg($urandom_range(REG_COUNT, INDEX_TOP), CFG_DATA_W'($urandom));
        for (int idx = 0; idx < REG_COUNT; idx++)
        begin
            w = board.reg_width(idx);
            case (style)
                SET_WILDCARD:
                    v = WILDCARD;
                SET_TOP:
                    v = (1 << (w - 1)) - 1;
                SET_BOTTOM:
                    v = -(1 << (w - 1));
                SET_IN_RANGE:
                    if ($urandom_range(0, 2) == 0)
                        v = WILDCARD;
                    else
                        case (idx % ENTRY_STRIDE)
                            REG_A0_WEEKDAY: v = $urandom_range(0, 6);
                            REG_A0_HOUR:    v = $urandom_range(0, 23);
                            default:        v = $urandom_range(0, 59);
                        endcase
                default:
                    v = $urandom;
            endcase
            // Bits above the register width are junk that the block must drop.
            mask = (1 << w) - 1;
            write_alarm_reg(idx, CFG_DATA_W'(($urandom & ~mask) | (v & mask)));
        end
        write_alarm_reg($urandom_range(REG_COUNT, INDEX_TOP), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_requests(int count);
        clock_now_t now;
        logic       func;
        int         b;
        int         r;
        for (int n = 0; n < count; n++)
        begin
            if (n % 16 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            now  = NOW_W'($urandom);
            func = ($urandom_range(0, 99) < 62) ? FUNC_TICK : FUNC_CHECK;
            // Most checks aim at one entry so alarms fire; the rest are plain noise.
            if (func == FUNC_CHECK && $urandom_range(0, 4) < 3)
            begin
                b = $urandom_range(0, ALARM_SLOTS - 1) * ENTRY_STRIDE;
                r = board.reg_signed(b + REG_A0_WEEKDAY);
                if (r >= 0)
                    now.weekday = 3'(r);
                r = board.reg_signed(b + REG_A0_HOUR);
                if (r >= 0)
                    now.hour = 5'(r);
                r = board.reg_signed(b + REG_A0_MINUTE);
                if (r >= 0)
                    now.minute = 6'(r);
                r = board.reg_signed(b + REG_A0_SECOND);
                if (r >= 0)
                    now.second = 6'(r);
            end
            send_request(func, now);
        end
    endtask

    task automatic run_setting(int style);
        load_alarms(style);
        random_requests(RANDOM_PER_SETTING);
        wait_idle();
    endtask

    initial
    begin
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset alarms: entry 0 at second 0, entry 1 at second 30, all else wildcard.
        send_ticks(1);
        send_request(FUNC_CHECK, {3'd7, 5'd31, 6'd63, 6'd63});
        send_request(FUNC_CHECK, {3'd0, 5'd0, 6'd0, 6'd0});
        send_ticks(9);
        // Restart mid blink, after the on-delay counter has already run out.
        send_request(FUNC_CHECK, {3'd6, 5'd23, 6'd59, 6'd30});
        send_ticks(10);
        send_request(FUNC_CHECK, {3'd3, 5'd12, 6'd30, 6'd45});
        send_request(FUNC_CHECK, {3'd5, 5'd17, 6'd42, 6'd0});
        wait_idle();

        run_setting(SET_WILDCARD);
        run_setting(SET_TOP);
        run_setting(SET_IN_RANGE);
        run_setting(SET_BOTTOM);
        run_setting(SET_RAW);
        run_setting(SET_IN_RANGE);
        run_setting(SET_IN_RANGE);
        run_setting(SET_WILDCARD);

        $display("Checked %0d results from %0d requests under %0d alarm settings.",
                 board.results, board.requests, settings_loaded);
        $display("Alarm entries fired %0d times; %0d errors found.", board.firings, board.errors);
        if (board.errors == 0)
            $display("tb_cron_alarm_blink_sequencer: clean");
        else
            $display("tb_cron_alarm_blink_sequencer: errors");
        $finish;
    end

endmodule
